// ----- hdl/firmware_image_chunk_receiver_core_macros.svh -----
// Assertion helpers.
`ifndef FIRMWARE_IMAGE_CHUNK_RECEIVER_CORE_MACROS_SVH
`define FIRMWARE_IMAGE_CHUNK_RECEIVER_CORE_MACROS_SVH

`define FICR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FICR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ficr_pkg.sv -----
package ficr_pkg;

    localparam logic [2:0] ACT_ACK     = 3'd0;
    localparam logic [2:0] ACT_REQ     = 3'd1;
    localparam logic [2:0] ACT_WRITE   = 3'd2;
    localparam logic [2:0] ACT_ABORT   = 3'd3;
    localparam logic [2:0] ACT_END     = 3'd4;
    localparam logic [2:0] ACT_RESTART = 3'd5;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_TOO_BIG  = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_LEN      = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_RX     = 2'd1;
    localparam logic [1:0] MODE_ERR    = 2'd2;
    localparam logic [1:0] MODE_ACT    = 2'd3;

    localparam logic [1:0] KIND_REQ    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_TMO    = 2'd2;
    localparam logic [1:0] KIND_BEAT   = 2'd3;

    localparam logic [15:0] CRC_POLY   = 16'h1021;

    typedef struct packed {
        logic start;
        logic [23:0] dividend;
        logic [15:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [15:0] count;
    } div_rsp_t;

    function automatic logic [15:0] crc_bit(input logic [15:0] c);
        crc_bit = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    endfunction

endpackage

// ----- hdl/ficr_div.sv -----
module ficr_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  ficr_pkg::div_cmd_t cmd,
    output ficr_pkg::div_rsp_t rsp
);
    import ficr_pkg::*;

    logic [23:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [24:0] ceil_q;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[23]};
        if (cmd.start)
        begin
            quo_next  = cmd.dividend;
            rem_next  = '0;
            dvs_next  = cmd.divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        ceil_q = {1'b0, quo_reg} + {24'd0, (rem_reg != '0)};
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (dvs_reg == '0 || ceil_q > 25'd65535)
            rsp.count = 16'hFFFF;
        else
            rsp.count = ceil_q[15:0];
    end

endmodule

// ----- hdl/firmware_image_chunk_receiver_core.sv -----
// channel | handshake          | payload
// in      | in_valid/in_stall  | kind img_bytes chunk_bytes image_crc from_self data_byte chunk_end
// out     | out_valid/out_stall| action success status to_desktop chunk_index write_address
//         |                    | write_data write_bytes timer_run new_mode last
// cfg     | cfg_we             | cfg_data (slot_size)
// A data byte is handled as the take, 8 CRC bit steps in the CRC shift unit, then a wrap-up.
// A request passes through the take, the 24-step restoring divider, then ack and request (or a too-big ack).
// A page flush first reads the page store, then emits one word per cycle while the output is not stalled.
// in_stall is high whenever the sequencer is not idle or a result is pending.
// Reset is asynchronous and clears all control state; the page store is not cleared.
module firmware_image_chunk_receiver_core
#(
    parameter int PAGE_BYTES  = 256,
    parameter int MAX_RETRIES = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [24:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [23:0] img_bytes,
    input  logic [15:0] chunk_bytes,
    input  logic [15:0] image_crc,
    input  logic        from_self,
    input  logic [7:0]  data_byte,
    input  logic        chunk_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic        success,
    output logic [2:0]  status,
    output logic        to_desktop,
    output logic [15:0] chunk_index,
    output logic [23:0] write_address,
    output logic [63:0] write_data,
    output logic [3:0]  write_bytes,
    output logic        timer_run,
    output logic [1:0]  new_mode,
    output logic        last
);
    import ficr_pkg::*;

    localparam int PW  = (PAGE_BYTES + 7) / 8;
    localparam int WAW = (PW > 1) ? $clog2(PW) : 1;
    localparam int FW  = $clog2(PAGE_BYTES + 1);
    localparam logic [FW-1:0] PAGE_FULL = FW'(PAGE_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_ACK   = 4'd2;
    localparam logic [3:0] S_REQ   = 4'd3;
    localparam logic [3:0] S_CRC   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_AFTER = 4'd7;
    localparam logic [3:0] S_END   = 4'd8;
    localparam logic [3:0] S_ONE   = 4'd9;

    logic [24:0] slot_reg;
    logic [3:0]  st_reg, st_next;
    logic [1:0]  mode_reg, mode_next;
    logic [23:0] esize_reg, esize_next;
    logic [15:0] ecrc_reg, ecrc_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] cc_reg, cc_next;
    logic [3:0]  retry_reg, retry_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [23:0] off_reg, off_next;
    logic [15:0] crc_reg, crc_next;
    logic        self_reg, self_next;
    logic        timer_reg, timer_next;
    logic [2:0]  bit_reg, bit_next;
    logic        cend_reg, cend_next;
    logic [FW-1:0] nb_reg, nb_next;
    logic [WAW-1:0] wi_reg, wi_next;
    logic        flush_reg, flush_next;
    logic        ovl_reg, ovl_next;
    logic [2:0]  oact_reg, oact_next;
    logic        osucc_reg, osucc_next;
    logic [2:0]  ostat_reg, ostat_next;
    logic        odesk_reg, odesk_next;
    logic [15:0] oidx_reg, oidx_next;
    logic [23:0] oaddr_reg, oaddr_next;
    logic [63:0] odata_reg, odata_next;
    logic [3:0]  obytes_reg, obytes_next;
    logic        olast_reg, olast_next;
    logic [3:0]  ret_reg, ret_next;

    logic [63:0] mem [PW];
    logic [63:0] rd_reg;
    logic        mem_we;
    logic [WAW-1:0] mem_wa;
    logic [63:0] mem_wd;
    logic [WAW-1:0] rd_addr;

    div_cmd_t dcmd;
    div_rsp_t drsp;

    logic        take_in, out_free;
    logic [FW-1:0] rem_n;
    logic [3:0]  nbw;
    logic [63:0] mask;
    logic [FW-1:0] fill_inc;
    logic [WAW-1:0] wsel;
    logic [2:0]  bsel;

    ficr_div u_div (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .rsp(drsp));

    assign out_free = !ovl_reg || !out_stall;
    assign in_stall = (st_reg != S_IDLE) || ovl_reg;
    assign take_in  = in_valid && !in_stall;

    assign fill_inc = fill_reg + FW'(1);
    assign wsel     = WAW'(fill_reg >> 3);
    assign bsel     = fill_reg[2:0];
    assign rem_n    = nb_reg - FW'({wi_reg, 3'b000});
    assign nbw      = (rem_n > FW'(8)) ? 4'd8 : 4'(rem_n);

    always_comb
    begin
        mask = '1;
        if (nbw < 4'd8)
            mask = (64'd1 << {nbw, 3'b000}) - 64'd1;
    end

    always_comb
    begin
        st_next    = st_reg;
        mode_next  = mode_reg;
        esize_next = esize_reg;
        ecrc_next  = ecrc_reg;
        total_next = total_reg;
        cc_next    = cc_reg;
        retry_next = retry_reg;
        fill_next  = fill_reg;
        off_next   = off_reg;
        crc_next   = crc_reg;
        self_next  = self_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        cend_next  = cend_reg;
        nb_next    = nb_reg;
        wi_next    = wi_reg;
        flush_next = flush_reg;
        ret_next   = ret_reg;
        ovl_next   = ovl_reg && out_stall;
        oact_next  = oact_reg;
        osucc_next = osucc_reg;
        ostat_next = ostat_reg;
        odesk_next = odesk_reg;
        oidx_next  = oidx_reg;
        oaddr_next = oaddr_reg;
        odata_next = odata_reg;
        obytes_next = obytes_reg;
        olast_next = olast_reg;
        dcmd       = '0;
        mem_we     = 1'b0;
        mem_wa     = wsel;
        mem_wd     = '0;
        rd_addr    = wsel;

        case (st_reg)
            S_IDLE:
            begin
                if (take_in)
                begin
                    cend_next = chunk_end;
                    case (kind)
                        KIND_REQ:
                        begin
                            if (mode_reg == MODE_IDLE || mode_reg == MODE_ERR)
                            begin
                                self_next  = from_self;
                                esize_next = img_bytes;
                                ecrc_next  = image_crc;
                                dcmd.start = 1'b1;
                                dcmd.dividend = img_bytes;
                                dcmd.divisor  = chunk_bytes;
                                st_next = S_DIV;
                            end
                        end
                        KIND_DATA:
                        begin
                            if (mode_reg == MODE_RX)
                            begin
                                timer_next = 1'b0;
                                crc_next = crc_reg ^ {data_byte, 8'd0};
                                bit_next = 3'd0;
                                mem_we = 1'b1;
                                mem_wa = wsel;
                                mem_wd = (bsel == 3'd0) ? 64'd0 : rd_reg;
                                mem_wd[{bsel, 3'b000} +: 8] = data_byte;
                                st_next = S_CRC;
                            end
                        end
                        KIND_TMO:
                        begin
                            if (mode_reg == MODE_RX)
                            begin
                                if (retry_reg < 4'd15)
                                    retry_next = retry_reg + 4'd1;
                                if (retry_next >= 4'(MAX_RETRIES))
                                begin
                                    timer_next = 1'b0;
                                    mode_next = MODE_ERR;
                                    if (!self_reg)
                                    begin
                                        oact_next = ACT_ABORT;
                                        ostat_next = ST_TIMEOUT;
                                        osucc_next = 1'b0;
                                        odesk_next = 1'b0;
                                        st_next = S_ONE;
                                    end
                                end
                                else
                                begin
                                    ret_next = S_IDLE;
                                    st_next = S_REQ;
                                end
                            end
                        end
                        default:
                        begin
                            if (mode_reg == MODE_RX)
                            begin
                                timer_next = 1'b1;
                                oact_next = ACT_RESTART;
                                ostat_next = ST_NONE;
                                osucc_next = 1'b0;
                                odesk_next = 1'b0;
                                st_next = S_ONE;
                            end
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    total_next = drsp.count;
                    if (slot_reg > {1'b0, esize_reg})
                    begin
                        mode_next  = MODE_RX;
                        cc_next    = '0;
                        retry_next = '0;
                        fill_next  = '0;
                        off_next   = '0;
                        crc_next   = '0;
                        timer_next = 1'b1;
                        st_next    = S_ACK;
                    end
                    else
                    begin
                        mode_next  = MODE_IDLE;
                        timer_next = 1'b0;
                        if (!self_reg)
                        begin
                            oact_next = ACT_ACK;
                            osucc_next = 1'b0;
                            ostat_next = ST_TOO_BIG;
                            odesk_next = 1'b0;
                            st_next = S_ONE;
                        end
                        else
                            st_next = S_IDLE;
                    end
                end
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    ovl_next = 1'b1;
                    oact_next = ACT_ACK;
                    osucc_next = 1'b1;
                    ostat_next = ST_NONE;
                    odesk_next = self_reg;
                    oidx_next = '0;
                    oaddr_next = '0;
                    odata_next = '0;
                    obytes_next = '0;
                    olast_next = 1'b0;
                    ret_next = S_IDLE;
                    st_next = S_REQ;
                end
            end
            S_REQ:
            begin
                if (out_free)
                begin
                    timer_next = 1'b1;
                    ovl_next = 1'b1;
                    oact_next = ACT_REQ;
                    osucc_next = 1'b0;
                    ostat_next = ST_NONE;
                    odesk_next = self_reg;
                    oidx_next = cc_reg;
                    oaddr_next = '0;
                    odata_next = '0;
                    obytes_next = '0;
                    olast_next = 1'b1;
                    st_next = ret_reg;
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    ovl_next = 1'b1;
                    oidx_next = '0;
                    oaddr_next = '0;
                    odata_next = '0;
                    obytes_next = '0;
                    olast_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            S_CRC:
            begin
                crc_next = crc_bit(crc_reg);
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    fill_next = fill_inc;
                    // timer and mode settle before any result of this item leaves
                    if (cend_reg)
                    begin
                        if ((cc_reg + 16'd1) < total_reg)
                            timer_next = 1'b1;
                        else if (esize_reg != off_reg + 24'(fill_inc))
                            mode_next = MODE_ERR;
                        else if (ecrc_reg == crc_next)
                            mode_next = MODE_ACT;
                        else
                            mode_next = MODE_ERR;
                    end
                    if (fill_inc >= PAGE_FULL)
                    begin
                        nb_next = PAGE_FULL;
                        wi_next = '0;
                        flush_next = 1'b0;
                        st_next = S_RD;
                    end
                    else
                        st_next = S_AFTER;
                end
            end
            S_RD:
            begin
                rd_addr = wi_reg;
                st_next = S_WR;
            end
            S_WR:
            begin
                rd_addr = wi_reg;
                if (out_free)
                begin
                    ovl_next = 1'b1;
                    oact_next = ACT_WRITE;
                    osucc_next = 1'b0;
                    ostat_next = ST_NONE;
                    odesk_next = 1'b0;
                    oidx_next = '0;
                    oaddr_next = off_reg + 24'({wi_reg, 3'b000});
                    odata_next = rd_reg & mask;
                    obytes_next = nbw;
                    if (rem_n <= FW'(8))
                    begin
                        off_next = off_reg + 24'(nb_reg);
                        fill_next = '0;
                        if (flush_reg)
                        begin
                            olast_next = 1'b0;
                            st_next = S_END;
                        end
                        else
                        begin
                            olast_next = !cend_reg;
                            st_next = S_AFTER;
                        end
                    end
                    else
                    begin
                        olast_next = 1'b0;
                        wi_next = wi_reg + WAW'(1);
                        rd_addr = wi_reg + WAW'(1);
                        st_next = S_WR;
                    end
                end
            end
            S_AFTER:
            begin
                if (!cend_reg)
                    st_next = S_IDLE;
                else
                begin
                    cc_next = cc_reg + 16'd1;
                    retry_next = '0;
                    if (cc_next < total_reg)
                    begin
                        ret_next = S_IDLE;
                        st_next = S_REQ;
                    end
                    else if (fill_reg != '0)
                    begin
                        nb_next = fill_reg;
                        wi_next = '0;
                        flush_next = 1'b1;
                        st_next = S_RD;
                    end
                    else
                        st_next = S_END;
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    ovl_next = 1'b1;
                    oact_next = ACT_END;
                    odesk_next = self_reg;
                    if (esize_reg != off_reg)
                    begin
                        osucc_next = 1'b0;
                        ostat_next = ST_LEN;
                    end
                    else if (ecrc_reg == crc_reg)
                    begin
                        osucc_next = 1'b1;
                        ostat_next = ST_NONE;
                    end
                    else
                    begin
                        osucc_next = 1'b0;
                        ostat_next = ST_CRC;
                    end
                    oidx_next = '0;
                    oaddr_next = '0;
                    odata_next = '0;
                    obytes_next = '0;
                    olast_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= 25'd1048576;
            st_reg    <= S_IDLE;
            mode_reg  <= MODE_IDLE;
            esize_reg <= '0;
            ecrc_reg  <= '0;
            total_reg <= '0;
            cc_reg    <= '0;
            retry_reg <= '0;
            fill_reg  <= '0;
            off_reg   <= '0;
            crc_reg   <= '0;
            self_reg  <= 1'b0;
            timer_reg <= 1'b0;
            ovl_reg   <= 1'b0;
            bit_reg   <= '0;
            wi_reg    <= '0;
            nb_reg    <= '0;
            flush_reg <= 1'b0;
            cend_reg  <= 1'b0;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            if (cfg_we)
                slot_reg <= cfg_data;
            st_reg    <= st_next;
            mode_reg  <= mode_next;
            esize_reg <= esize_next;
            ecrc_reg  <= ecrc_next;
            total_reg <= total_next;
            cc_reg    <= cc_next;
            retry_reg <= retry_next;
            fill_reg  <= fill_next;
            off_reg   <= off_next;
            crc_reg   <= crc_next;
            self_reg  <= self_next;
            timer_reg <= timer_next;
            ovl_reg   <= ovl_next;
            bit_reg   <= bit_next;
            wi_reg    <= wi_next;
            nb_reg    <= nb_next;
            flush_reg <= flush_next;
            cend_reg  <= cend_next;
            ret_reg   <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oact_reg    <= oact_next;
        osucc_reg   <= osucc_next;
        ostat_reg   <= ostat_next;
        odesk_reg   <= odesk_next;
        oidx_reg    <= oidx_next;
        oaddr_reg   <= oaddr_next;
        odata_reg   <= odata_next;
        obytes_reg  <= obytes_next;
        olast_reg   <= olast_next;
    end

    // page store: read address follows the fill pointer outside page emission
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[rd_addr];
    end

    assign out_valid     = ovl_reg;
    assign action        = oact_reg;
    assign success       = osucc_reg;
    assign status        = ostat_reg;
    assign to_desktop    = odesk_reg;
    assign chunk_index   = oidx_reg;
    assign write_address = oaddr_reg;
    assign write_data    = odata_reg;
    assign write_bytes   = obytes_reg;
    assign timer_run     = timer_reg;
    assign new_mode      = mode_reg;
    assign last          = olast_reg;

`include "firmware_image_chunk_receiver_core_macros.svh"

    `FICR_ASSERT_IMPL(a_no_take_busy, clk, rst_n, st_reg != S_IDLE, in_stall,
                      "took item while busy")
    `FICR_ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_reg <= PAGE_FULL,
                      "page fill out of range")
    `FICR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                      out_valid && $stable(action) && $stable(write_data),
                      "stalled item changed")
    `FICR_ASSERT_IMPL(a_bytes_range, clk, rst_n, out_valid && action == ACT_WRITE,
                      write_bytes != 4'd0 && write_bytes <= 4'd8, "bad write byte count")

endmodule
